// File: src/quad_motor_mixer_pwm_defines.svh
// Assertion macros for the quad motor mixer.
// Used by quad_motor_mixer_pwm.sv; expects clk and rst in scope.
`ifndef QUAD_MOTOR_MIXER_PWM_DEFINES_SVH
`define QUAD_MOTOR_MIXER_PWM_DEFINES_SVH

// same-cycle implication
`define QMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/qmm_pkg.sv
// Shared constants, types and helper functions for the quad motor mixer.
// No dependencies; imported by qmm_div, quad_motor_mixer_pwm and the testbench.
package qmm_pkg;

  localparam int CMD_W     = 10;
  localparam int GAIN_W    = 8;
  localparam int GAIN25_W  = 13;
  localparam int ACC_W     = 30;
  localparam int MAG_W     = 29;
  localparam int DEN_W     = 17;
  localparam int QUO_W     = 11;
  localparam int DSR_W     = DEN_W + QUO_W - 1;
  localparam int CMP_W     = 14;
  localparam int CFG_W     = 10;
  localparam int REG_IDX_W = 3;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_MIX   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PITCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROLL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PR_GAIN     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_YAW_GAIN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT_GAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_MIN   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_MAX   = 3'd5;

  localparam logic [GAIN_W-1:0] RST_PR_GAIN     = 8'd141;
  localparam logic [GAIN_W-1:0] RST_YAW_GAIN    = 8'd150;
  localparam logic [GAIN_W-1:0] RST_HEIGHT_GAIN = 8'd153;
  localparam logic [CMD_W-1:0]  RST_MOTOR_MIN   = 10'd50;
  localparam logic [CMD_W-1:0]  RST_MOTOR_MAX   = 10'd900;
  localparam logic [CMD_W-1:0]  RST_CMD         = 10'd50;
  localparam logic [CMP_W-1:0]  IDLE_COMPARE    = 14'd6250;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_stat_t;

  // gain in tenths times 25
  function automatic logic [GAIN25_W-1:0] times25(input logic [GAIN_W-1:0] g);
    logic [GAIN25_W-1:0] x;
    x = GAIN25_W'(g);
    return (x << 4) + (x << 3) + x;
  endfunction

  // upper clamp first, lower clamp last; neg forces the lower limit
  function automatic logic [CMD_W-1:0] clamp_cmd(input logic neg,
                                                 input logic [QUO_W-1:0] v,
                                                 input logic [CMD_W-1:0] lo,
                                                 input logic [CMD_W-1:0] hi);
    logic [CMD_W-1:0] t;
    t = (v > {1'b0, hi}) ? hi : v[CMD_W-1:0];
    if (neg || (t < lo)) t = lo;
    return t;
  endfunction

  // (base +/- thrust) / 16 toward zero, then clamp
  function automatic logic [CMD_W-1:0] simple_cmd(input logic signed [16:0] s,
                                                  input logic [CMD_W-1:0] lo,
                                                  input logic [CMD_W-1:0] hi);
    return clamp_cmd(s[16], s[14:4], lo, hi);
  endfunction

  // (M + 1000) * 25 / 4
  function automatic logic [CMP_W-1:0] compare_of(input logic [CMD_W-1:0] m);
    logic [15:0] x;
    logic [15:0] y;
    x = 16'(m) + 16'd1000;
    y = (x << 4) + (x << 3) + x;
    return y[15:2];
  endfunction

endpackage

// File: src/qmm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 11 bits.
// Quotient bit 10 set means the quotient is 1024 or more. Depends on qmm_pkg.
module qmm_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [qmm_pkg::MAG_W-1:0] num,
  input  logic [qmm_pkg::DEN_W-1:0] den,
  output qmm_pkg::div_stat_t       stat
);
  import qmm_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [MAG_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [QUO_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             ge;

  assign ge = rem >= MAG_W'(dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= {den, {(QUO_W - 1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (ge) rem <= rem - MAG_W'(dsr);
      quo <= {quo[QUO_W-2:0], ge};
      dsr <= dsr >> 1;
    end
  end

  assign stat.done = done;
  assign stat.quo  = quo;

endmodule

// File: src/quad_motor_mixer_pwm.sv
// Quad X-frame motor mixer with PWM compare output.
// Depends on qmm_pkg, qmm_div and quad_motor_mixer_pwm_defines.svh.
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata: thrusts, battery; tuser: low_power
// m_*      out  tvalid/tready      tdata: compare_m1..compare_m4
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Four-axis mode: a bit-serial gain multiply over the 13 gain bits, then one
// 11-step divider run per motor; a new item is taken only in idle.
// Pitch-only, roll-only and hold modes skip both and go straight to the command update.
// Reset is synchronous; motor commands return to 50, registers to defaults.
// A finished result waits in the output register; the next item is taken
// meanwhile and only its final load waits for m_tready.
`include "quad_motor_mixer_pwm_defines.svh"

module quad_motor_mixer_pwm (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [14:0] pitch_thrust, [29:15] roll_thrust, [41:30] yaw_thrust,
  // [56:42] height_thrust, [70:57] base_thrust, [85:71] battery_mv, [87:86] zero
  input  logic [87:0]                  s_tdata,
  // [0] low_power
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [13:0] compare_m1, [27:14] compare_m2, [41:28] compare_m3, [55:42] compare_m4
  output logic [55:0]                  m_tdata,
  input  logic                         cfg_we,
  input  logic [qmm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [qmm_pkg::CFG_W-1:0]     cfg_data
);
  import qmm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  localparam int BIT_W = $clog2(GAIN25_W);

  // configuration
  logic [MODE_W-1:0]   drone_mode;
  logic [GAIN25_W-1:0] pr_gain25;
  logic [GAIN25_W-1:0] yaw_gain25;
  logic [GAIN25_W-1:0] height_gain25;
  logic [CMD_W-1:0]    motor_min;
  logic [CMD_W-1:0]    motor_max;

  // latched item
  logic signed [14:0] p_q;
  logic signed [14:0] r_q;
  logic signed [11:0] y_q;
  logic signed [14:0] h_q;
  logic [13:0]        b_q;
  logic [14:0]        mv_q;
  logic               low_q;

  logic [2:0]              state;
  logic [BIT_W-1:0]        bcnt;
  logic [1:0]              mcnt;
  logic signed [ACC_W-1:0] acc [4];
  logic signed [ACC_W-1:0] acc_next [4];
  logic                    neg_q;
  logic [CMD_W-1:0]        cmd_new [4];
  logic [CMD_W-1:0]        motor_command [4];

  logic                    s_accept;
  logic                    out_free;
  logic signed [ACC_W-1:0] tp, tr, ty, th;
  logic [14:0]             mv_eff;
  logic                    div_start;
  logic [MAG_W-1:0]        div_num;
  div_stat_t               stat;
  logic signed [16:0]      b_ext, bp_minus, bp_plus, br_minus, br_plus;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drone_mode    <= MODE_MIX;
      pr_gain25     <= times25(RST_PR_GAIN);
      yaw_gain25    <= times25(RST_YAW_GAIN);
      height_gain25 <= times25(RST_HEIGHT_GAIN);
      motor_min     <= RST_MOTOR_MIN;
      motor_max     <= RST_MOTOR_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        drone_mode    <= cfg_data[MODE_W-1:0];
        REG_PR_GAIN:     pr_gain25     <= times25(cfg_data[GAIN_W-1:0]);
        REG_YAW_GAIN:    yaw_gain25    <= times25(cfg_data[GAIN_W-1:0]);
        REG_HEIGHT_GAIN: height_gain25 <= times25(cfg_data[GAIN_W-1:0]);
        REG_MOTOR_MIN:   motor_min     <= cfg_data;
        REG_MOTOR_MAX:   motor_max     <= cfg_data;
        default: ;
      endcase
    end
  end

  // bit-serial multiply, gain bits MSB first
  always_comb begin
    tp = pr_gain25[bcnt]     ? ACC_W'(p_q) : '0;
    tr = pr_gain25[bcnt]     ? ACC_W'(r_q) : '0;
    ty = yaw_gain25[bcnt]    ? ACC_W'(y_q) : '0;
    th = height_gain25[bcnt] ? ACC_W'(h_q) : '0;
    acc_next[0] = (acc[0] <<< 1) - tp - tr - ty + th;
    acc_next[1] = (acc[1] <<< 1) + tp - tr + ty + th;
    acc_next[2] = (acc[2] <<< 1) + tp + tr - ty + th;
    acc_next[3] = (acc[3] <<< 1) - tp + tr + ty + th;
  end

  assign mv_eff    = (mv_q == '0) ? 15'd1 : mv_q;
  assign div_start = (state == ST_LOAD);
  assign div_num   = acc[0][ACC_W-1] ? MAG_W'(-acc[0]) : MAG_W'(acc[0]);

  qmm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   ({mv_eff, 2'b00}),
    .stat  (stat)
  );

  assign b_ext    = 17'(b_q);
  assign bp_minus = b_ext - 17'(p_q);
  assign bp_plus  = b_ext + 17'(p_q);
  assign br_minus = b_ext - 17'(r_q);
  assign br_plus  = b_ext + 17'(r_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bcnt  <= '0;
      mcnt  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (s_accept) begin
          bcnt  <= BIT_W'(GAIN25_W - 1);
          mcnt  <= '0;
          state <= (drone_mode == MODE_MIX) ? ST_MUL : ST_FIN;
        end
        ST_MUL: begin
          bcnt <= bcnt - 1'b1;
          if (bcnt == '0) state <= ST_LOAD;
        end
        ST_LOAD: state <= ST_DIV;
        ST_DIV: if (stat.done) begin
          mcnt  <= mcnt + 1'b1;
          state <= (mcnt == 2'd3) ? ST_FIN : ST_LOAD;
        end
        ST_FIN: state <= ST_OUT;
        ST_OUT: if (out_free) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      p_q   <= s_tdata[14:0];
      r_q   <= s_tdata[29:15];
      y_q   <= s_tdata[41:30];
      h_q   <= s_tdata[56:42];
      b_q   <= s_tdata[70:57];
      mv_q  <= s_tdata[85:71];
      low_q <= s_tuser;
      for (int i = 0; i < 4; i++) acc[i] <= '0;
    end else if (state == ST_MUL) begin
      for (int i = 0; i < 4; i++) acc[i] <= acc_next[i];
    end else if (state == ST_DIV && stat.done) begin
      acc[0] <= acc[1];
      acc[1] <= acc[2];
      acc[2] <= acc[3];
    end
    if (state == ST_LOAD) neg_q <= acc[0][ACC_W-1];
    if (state == ST_DIV && stat.done) begin
      cmd_new[0] <= cmd_new[1];
      cmd_new[1] <= cmd_new[2];
      cmd_new[2] <= cmd_new[3];
      cmd_new[3] <= clamp_cmd(neg_q, stat.quo, motor_min, motor_max);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) motor_command[i] <= RST_CMD;
    end else if (state == ST_FIN) begin
      unique case (drone_mode)
        MODE_MIX: for (int i = 0; i < 4; i++) motor_command[i] <= cmd_new[i];
        MODE_PITCH: begin
          motor_command[0] <= simple_cmd(bp_minus, motor_min, motor_max);
          motor_command[1] <= simple_cmd(bp_plus,  motor_min, motor_max);
          motor_command[2] <= simple_cmd(bp_plus,  motor_min, motor_max);
          motor_command[3] <= simple_cmd(bp_minus, motor_min, motor_max);
        end
        MODE_ROLL: begin
          motor_command[0] <= simple_cmd(br_minus, motor_min, motor_max);
          motor_command[1] <= simple_cmd(br_minus, motor_min, motor_max);
          motor_command[2] <= simple_cmd(br_plus,  motor_min, motor_max);
          motor_command[3] <= simple_cmd(br_plus,  motor_min, motor_max);
        end
        MODE_HOLD: for (int i = 0; i < 4; i++)
          motor_command[i] <= clamp_cmd(1'b0, {1'b0, motor_command[i]}, motor_min, motor_max);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      for (int i = 0; i < 4; i++)
        m_tdata[i*CMP_W +: CMP_W] <= low_q ? IDLE_COMPARE : compare_of(motor_command[i]);
    end
  end

  `QMM_ASSERT_NOW(a_div_done_in_div, stat.done, state == ST_DIV, "divider done outside DIV")
  `QMM_ASSERT_NEXT(a_mix_starts_mul, s_accept && drone_mode == MODE_MIX, state == ST_MUL, "mix item did not start multiply")
  `QMM_ASSERT_NEXT(a_out_loads, state == ST_OUT && out_free, m_tvalid && state == ST_IDLE, "result not loaded")

endmodule

// File: sim/quad_motor_mixer_pwm_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for quad_motor_mixer_pwm: directed and random control ticks are
// predicted by a scoreboard class and compared with every compare-value transfer.
// Depends on qmm_pkg and the quad_motor_mixer_pwm RTL.
module quad_motor_mixer_pwm_test;
  import qmm_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 66;

  typedef struct {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
    logic signed [11:0] yaw;
    logic signed [14:0] height;
    logic [13:0]        base;
    logic [14:0]        mv;
    logic               low;
  } tick_t;

  class mix_scoreboard;
    logic [MODE_W-1:0] mode;
    logic [GAIN_W-1:0] pr_gain;
    logic [GAIN_W-1:0] yaw_gain;
    logic [GAIN_W-1:0] height_gain;
    logic [CMD_W-1:0]  cmd_min;
    logic [CMD_W-1:0]  cmd_max;
    logic [CMD_W-1:0]  motor_cmd [4];
    logic [55:0]       pending [$];
    int                errors;

    function new();
      mode = MODE_MIX;
      pr_gain = RST_PR_GAIN;
      yaw_gain = RST_YAW_GAIN;
      height_gain = RST_HEIGHT_GAIN;
      cmd_min = RST_MOTOR_MIN;
      cmd_max = RST_MOTOR_MAX;
      foreach (motor_cmd[i]) motor_cmd[i] = RST_CMD;
      errors = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_MODE:        mode = val[MODE_W-1:0];
        REG_PR_GAIN:     pr_gain = val[GAIN_W-1:0];
        REG_YAW_GAIN:    yaw_gain = val[GAIN_W-1:0];
        REG_HEIGHT_GAIN: height_gain = val[GAIN_W-1:0];
        REG_MOTOR_MIN:   cmd_min = val[CMD_W-1:0];
        REG_MOTOR_MAX:   cmd_max = val[CMD_W-1:0];
        default: ;
      endcase
    endfunction

    // mixes one tick, updates the stored commands, queues the compare values
    function void take_tick(tick_t t);
      longint p, r, b, mv, den, gp, gr, gy, gh, v;
      longint raw [4];
      logic [55:0] cmp;
      p = longint'(t.pitch);
      r = longint'(t.roll);
      b = longint'(t.base);
      case (mode)
        MODE_MIX: begin
          mv = (t.mv == 0) ? 1 : longint'(t.mv);
          den = 4 * mv;
          gp = longint'(pr_gain) * p;
          gr = longint'(pr_gain) * r;
          gy = longint'(yaw_gain) * longint'(t.yaw);
          gh = longint'(height_gain) * longint'(t.height);
          raw[0] = ((-gp - gr - gy + gh) * 25) / den;
          raw[1] = (( gp - gr + gy + gh) * 25) / den;
          raw[2] = (( gp + gr - gy + gh) * 25) / den;
          raw[3] = ((-gp + gr + gy + gh) * 25) / den;
        end
        MODE_PITCH: begin
          raw[0] = (b - p) / 16;
          raw[1] = (b + p) / 16;
          raw[2] = (b + p) / 16;
          raw[3] = (b - p) / 16;
        end
        MODE_ROLL: begin
          raw[0] = (b - r) / 16;
          raw[1] = (b - r) / 16;
          raw[2] = (b + r) / 16;
          raw[3] = (b + r) / 16;
        end
        MODE_HOLD: begin
          foreach (raw[i]) raw[i] = longint'(motor_cmd[i]);
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        v = raw[i];
        if (v > longint'(cmd_max)) v = longint'(cmd_max);
        if (v < longint'(cmd_min)) v = longint'(cmd_min);
        motor_cmd[i] = v[CMD_W-1:0];
        cmp[CMP_W*i +: CMP_W] = t.low ? IDLE_COMPARE
                                      : CMP_W'((int'(motor_cmd[i]) + 1000) * 25 / 4);
      end
      pending.push_back(cmp);
    endfunction

    function void check_compares(logic [55:0] got);
      logic [55:0] want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected compare transfer %h", got);
        return;
      end
      want = pending.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got[CMP_W*i +: CMP_W] !== want[CMP_W*i +: CMP_W]) begin
          errors++;
          if (errors <= 10)
            $display("compare_m%0d mismatch: expected %0d, got %0d", i + 1,
                     want[CMP_W*i +: CMP_W], got[CMP_W*i +: CMP_W]);
        end
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [87:0]          s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [55:0]          m_tdata;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int            send_idle_pct;
  int            recv_stall_pct;
  mix_scoreboard sb;

  quad_motor_mixer_pwm dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready = !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_compares(m_tdata);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic tick_t mk(int p, int r, int y, int h, int b, int mv, bit low);
    tick_t t;
    t.pitch = 15'(p);
    t.roll = 15'(r);
    t.yaw = 12'(y);
    t.height = 15'(h);
    t.base = 14'(b);
    t.mv = 15'(mv);
    t.low = low;
    return t;
  endfunction

  // mostly flyable ticks, the rest raw bit patterns
  function automatic tick_t rand_tick();
    tick_t t;
    if ($urandom_range(3) != 0) begin
      t.pitch = 15'(int'($urandom_range(6000)) - 3000);
      t.roll = 15'(int'($urandom_range(6000)) - 3000);
      t.yaw = 12'(int'($urandom_range(3200)) - 1600);
      t.height = 15'($urandom_range(16383, 4000));
      t.base = 14'($urandom_range(16383, 6000));
      t.mv = 15'($urandom_range(16800, 9000));
    end else begin
      t.pitch = 15'($urandom);
      t.roll = 15'($urandom);
      t.yaw = 12'($urandom);
      t.height = 15'($urandom);
      t.base = 14'($urandom);
      t.mv = 15'($urandom);
    end
    t.low = ($urandom_range(9) == 0);
    return t;
  endfunction

  function automatic int pick_gain();
    int k;
    k = $urandom_range(9);
    if (k < 2) return 0;
    if (k < 4) return 255;
    return $urandom_range(255);
  endfunction

  task automatic drive_tick(input tick_t t);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {2'b00, t.mv, t.base, t.height, t.yaw, t.roll, t.pitch};
    s_tuser = t.low;
    do @(posedge clk); while (!s_tready);
    sb.take_tick(t);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(val);
    sb.set_reg(idx, CFG_W'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic shuffle_config(input int ph);
    logic [MODE_W-1:0] m;
    int lo, hi;
    case (ph)
      2:       m = MODE_PITCH;
      4:       m = MODE_ROLL;
      5:       m = MODE_HOLD;
      default: m = MODE_MIX;
    endcase
    if (ph == 7) begin
      lo = 0;
      hi = 1023;
    end else if (ph == 5) begin
      lo = $urandom_range(600, 100);
      hi = $urandom_range(900, 300);
    end else begin
      lo = $urandom_range(300);
      hi = $urandom_range(1023, 500);
    end
    case (ph % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
    write_reg(REG_MODE, int'(m));
    write_reg(REG_PR_GAIN, pick_gain());
    write_reg(REG_YAW_GAIN, pick_gain());
    write_reg(REG_HEIGHT_GAIN, pick_gain());
    write_reg(REG_MOTOR_MIN, lo);
    write_reg(REG_MOTOR_MAX, hi);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // four-axis mix at reset settings
    drive_tick(mk(0, 0, 0, 0, 0, 12000, 0));
    drive_tick(mk(0, 0, 0, 16383, 0, 1000, 0));
    drive_tick(mk(0, 0, 0, -16384, 0, 1000, 0));
    drive_tick(mk(16383, -16384, 2047, 8000, 0, 0, 0));   // zero battery reads as 1 mV
    drive_tick(mk(-16384, 16383, -2048, 8000, 16383, 32767, 0));
    drive_tick(mk(500, -300, 800, 10000, 4000, 12000, 0));
    drive_tick(mk(500, -300, 800, 10000, 4000, 12000, 1));
    drive_tick(mk(-1, -1, -1, -1, 16383, 32767, 1));
    drain();

    write_reg(REG_PR_GAIN, 255);
    write_reg(REG_YAW_GAIN, 0);
    write_reg(REG_HEIGHT_GAIN, 255);
    write_reg(REG_MOTOR_MIN, 0);
    write_reg(REG_MOTOR_MAX, 1023);
    drive_tick(mk(0, 0, 0, 16383, 0, 1000, 0));
    drive_tick(mk(0, 0, 0, -1, 0, 30000, 0));    // small negative quotient truncates to 0
    drain();

    write_reg(REG_MODE, MODE_PITCH);
    drive_tick(mk(16383, 0, 0, 0, 16383, 12000, 0));
    drive_tick(mk(-16384, 0, 0, 0, 0, 12000, 0));
    drive_tick(mk(15, 0, 0, 0, 0, 12000, 0));
    drive_tick(mk(160, 0, 0, 0, 12800, 12000, 1));
    drain();

    write_reg(REG_MODE, MODE_ROLL);
    drive_tick(mk(0, 16383, 0, 0, 16383, 12000, 0));
    drive_tick(mk(0, -16384, 0, 0, 0, 12000, 0));
    drive_tick(mk(0, -17, 0, 0, 0, 12000, 0));
    drain();

    // hold re-clamps the stored commands
    write_reg(REG_MOTOR_MIN, 100);
    write_reg(REG_MOTOR_MAX, 700);
    write_reg(REG_MODE, MODE_HOLD);
    drive_tick(mk(3000, -3000, 1600, 16383, 9000, 12000, 0));
    drive_tick(mk(3000, -3000, 1600, 16383, 9000, 12000, 1));
    drain();

    // crossed limits: lower clamp wins
    write_reg(REG_MOTOR_MIN, 1023);
    write_reg(REG_MOTOR_MAX, 0);
    write_reg(REG_MODE, MODE_MIX);
    drive_tick(mk(500, -300, 800, 10000, 4000, 12000, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      shuffle_config(ph);
      repeat (PHASE_ITEMS) drive_tick(rand_tick());
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/qmm_pkg.sv
src/qmm_div.sv
src/quad_motor_mixer_pwm.sv
sim/quad_motor_mixer_pwm_test.sv
